[rtl/acet_pkg.sv]
package acet_pkg;

   // Default sizing of the block.
   localparam int MAX_COLLIDERS_DEF = 64;
   localparam int COORD_BITS_DEF    = 16;

   // Collider ids arrive as fixed 6-bit fields.
   localparam int ID_BITS = 6;

   // Entries in the command queue between front and back (a power of two).
   localparam int QUEUE_DEPTH = 2;

   // Operation codes of the input opcode field.
   localparam logic OP_TEST   = 1'b0;
   localparam logic OP_FORGET = 1'b1;

   // Contact event codes on the result channel.
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } event_type;

   // Classified command handed from the front to the back.
   // For a forget, lo carries the id to forget and live says it is in range.
   // For a test, live says both ids are in range and distinct.
   typedef struct packed {
      logic               forget;
      logic               live;
      logic               hit;
      logic               dying;
      logic [ID_BITS-1:0] lo;
      logic [ID_BITS-1:0] hi;
   } cmd_type;

endpackage

[rtl/acet_front.sv]
module acet_front #(
   parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEF,
   parameter int COORD_BITS    = acet_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [acet_pkg::ID_BITS-1:0]   req_id_a,
   input  logic [acet_pkg::ID_BITS-1:0]   req_id_b,
   input  logic signed [COORD_BITS-1:0]   req_a_x,
   input  logic signed [COORD_BITS-1:0]   req_a_y,
   input  logic [COORD_BITS-2:0]          req_a_w,
   input  logic [COORD_BITS-2:0]          req_a_h,
   input  logic signed [COORD_BITS-1:0]   req_b_x,
   input  logic signed [COORD_BITS-1:0]   req_b_y,
   input  logic [COORD_BITS-2:0]          req_b_w,
   input  logic [COORD_BITS-2:0]          req_b_h,
   input  logic                           req_dying,
   output logic                           push_valid,
   input  logic                           push_stall,
   output acet_pkg::cmd_type              push_cmd
);
   import acet_pkg::*;

   // Twice a centre distance needs two bits more than a coordinate.
   localparam int DW = COORD_BITS + 2;

   logic    front_valid_ff;
   logic    front_valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    a_in_range;
   logic    b_in_range;
   logic    hit_x;
   logic    hit_y;

   // One axis: 2*|pa - pb| < sa + sb, written as -s < 2*d < s.
   function automatic logic axis_hit(input logic signed [COORD_BITS-1:0] pa,
                                     input logic [COORD_BITS-2:0] sa,
                                     input logic signed [COORD_BITS-1:0] pb,
                                     input logic [COORD_BITS-2:0] sb);
      logic signed [DW-1:0] d2;
      logic signed [DW-1:0] s;
      d2 = (DW'(pa) - DW'(pb)) <<< 1;
      s  = $signed(DW'(sa)) + $signed(DW'(sb));
      return (d2 < s) && (d2 > -s);
   endfunction

   assign hit_x      = axis_hit(req_a_x, req_a_w, req_b_x, req_b_w);
   assign hit_y      = axis_hit(req_a_y, req_a_h, req_b_y, req_b_h);
   assign a_in_range = 32'(req_id_a) < MAX_COLLIDERS;
   assign b_in_range = 32'(req_id_b) < MAX_COLLIDERS;

   // Classify the incoming item into a command for the back end.
   always_comb begin
      cmd_in.forget = (req_opcode == OP_FORGET);
      cmd_in.dying  = req_dying;
      if (req_opcode == OP_FORGET) begin
         cmd_in.live = a_in_range;
         cmd_in.hit  = 1'b0;
         cmd_in.lo   = req_id_a;
         cmd_in.hi   = req_id_a;
      end else begin
         cmd_in.live = a_in_range && b_in_range && (req_id_a != req_id_b);
         cmd_in.hit  = hit_x && hit_y;
         cmd_in.lo   = (req_id_a < req_id_b) ? req_id_a : req_id_b;
         cmd_in.hi   = (req_id_a < req_id_b) ? req_id_b : req_id_a;
      end
   end

   // The front register takes a new transfer unless it holds one the queue refuses.
   assign req_stall      = front_valid_ff && push_stall;
   assign front_valid_in = req_stall ? front_valid_ff : req_valid;
   assign push_valid     = front_valid_ff;
   assign push_cmd       = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[rtl/acet_queue.sv]
module acet_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_stall,
   input  acet_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_take,
   output acet_pkg::cmd_type pop_cmd
);
   import acet_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = PTR_W + 1;

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_take && pop_valid;

   // Pointers wrap on their own since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/acet_back.sv]
module acet_back #(
   parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_take,
   input  acet_pkg::cmd_type pop_cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_event_res,
   output logic              rsp_overlap
);
   import acet_pkg::*;

   localparam int IDX_W = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } state_type;

   // Pair store: row lo holds the touching bit of pair (lo, hi) at column hi.
   logic [MAX_COLLIDERS-1:0] mem [MAX_COLLIDERS];
   logic [MAX_COLLIDERS-1:0] row_ff;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             wipe_ff;
   logic [IDX_W-1:0] fid_ff;
   logic [IDX_W-1:0] lo_ff;
   logic [IDX_W-1:0] hi_ff;
   logic             hit_ff;
   logic             dying_ff;
   logic             rsp_valid_ff;
   event_type        rsp_ev_ff;
   logic             rsp_ov_ff;

   logic                     out_free;
   logic                     rsp_load;
   logic                     prev_bit;
   logic                     new_bit;
   event_type                ev_in;
   logic                     mem_re;
   logic [IDX_W-1:0]         mem_raddr;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [MAX_COLLIDERS-1:0] mem_wdata;
   logic [IDX_W-1:0]         sweep_row;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop_take  = (state_ff == ST_IDLE) && pop_valid && out_free;
   assign sweep_row = IDX_W'(cnt_ff - 1'b1);

   // A result is loaded when a test finishes its read, or when a forget or a test that is not live is taken.
   assign rsp_load = (state_ff == ST_READ) ||
                     (pop_take && (pop_cmd.forget || !pop_cmd.live));

   // Contact decision from the stored bit and this test.
   assign prev_bit = row_ff[hi_ff];
   assign new_bit  = hit_ff && !dying_ff;

   always_comb begin
      if (hit_ff) begin
         if (prev_bit) begin
            ev_in = dying_ff ? EV_EXIT : EV_STAY;
         end else begin
            ev_in = dying_ff ? EV_NONE : EV_ENTER;
         end
      end else begin
         ev_in = prev_bit ? EV_EXIT : EV_NONE;
      end
   end

   // Memory port control: a test reads then writes one row; a sweep reads
   // row k while it writes back row k-1.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = IDX_W'(pop_cmd.lo);
      mem_we    = 1'b0;
      mem_waddr = lo_ff;
      mem_wdata = row_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_re = pop_take && !pop_cmd.forget && pop_cmd.live;
         end
         ST_READ: begin
            mem_we = 1'b1;
            for (int j = 0; j < MAX_COLLIDERS; j++) begin
               mem_wdata[j] = (IDX_W'(j) == hi_ff) ? new_bit : row_ff[j];
            end
         end
         ST_SWEEP: begin
            mem_re    = (cnt_ff < CNT_W'(MAX_COLLIDERS));
            mem_raddr = cnt_ff[IDX_W-1:0];
            mem_we    = (cnt_ff != '0);
            mem_waddr = sweep_row;
            for (int j = 0; j < MAX_COLLIDERS; j++) begin
               mem_wdata[j] = row_ff[j] && !wipe_ff && (sweep_row != fid_ff)
                              && (IDX_W'(j) != fid_ff);
            end
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         row_ff <= mem[mem_raddr];
      end
   end

   // Sequencer and output register. Reset starts a sweep that zeroes the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cnt_ff       <= '0;
         wipe_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_take) begin
                  if (pop_cmd.forget) begin
                     rsp_ev_ff    <= EV_NONE;
                     rsp_ov_ff    <= 1'b0;
                     fid_ff       <= IDX_W'(pop_cmd.lo);
                     cnt_ff       <= '0;
                     wipe_ff      <= 1'b0;
                     if (pop_cmd.live) begin
                        state_ff <= ST_SWEEP;
                     end
                  end else if (!pop_cmd.live) begin
                     rsp_ev_ff    <= EV_NONE;
                     rsp_ov_ff    <= pop_cmd.hit;
                  end else begin
                     lo_ff    <= IDX_W'(pop_cmd.lo);
                     hi_ff    <= IDX_W'(pop_cmd.hi);
                     hit_ff   <= pop_cmd.hit;
                     dying_ff <= pop_cmd.dying;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               rsp_ev_ff    <= ev_in;
               rsp_ov_ff    <= hit_ff;
               state_ff     <= ST_IDLE;
            end
            ST_SWEEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(MAX_COLLIDERS)) begin
                  wipe_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_ev_ff;
   assign rsp_overlap   = rsp_ov_ff;

endmodule

[rtl/aabb_contact_event_tracker_unit.sv]
// Contact event tracker for pairs of axis-aligned boxes.
// Input channel (req_): one transfer per pair test or per forget of one id.
// A test compares the two boxes (2*|centre distance| < sum of sizes, on
// both axes) and updates one touching bit per unordered id pair; a forget
// clears every pair bit that holds req_id_a.
// Result channel (rsp_): exactly one transfer per input transfer, in order,
// carrying the event code (none, enter, stay, exit) and the overlap flag.
// A pair test passes the front register, the queue, the read of its row in
// the pair store and the output register. The back end takes no new command
// until a test has finished the read-modify-write of the pair store through
// its single read and write port. A forget of an id in range holds the back
// end while it walks every row of the store.
// Reset: the store is zeroed by a pass over every row; input transfers are
// buffered during that pass and results follow once it ends.
// When the receiver stalls, the result holds in the output register; the
// queue between front and back keeps taking transfers until it fills, and
// then req_stall rises.
module aabb_contact_event_tracker_unit #(
   parameter int MAX_COLLIDERS = acet_pkg::MAX_COLLIDERS_DEF,
   parameter int COORD_BITS    = acet_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [acet_pkg::ID_BITS-1:0]   req_id_a,
   input  logic [acet_pkg::ID_BITS-1:0]   req_id_b,
   input  logic signed [COORD_BITS-1:0]   req_a_x,
   input  logic signed [COORD_BITS-1:0]   req_a_y,
   input  logic [COORD_BITS-2:0]          req_a_w,
   input  logic [COORD_BITS-2:0]          req_a_h,
   input  logic signed [COORD_BITS-1:0]   req_b_x,
   input  logic signed [COORD_BITS-1:0]   req_b_y,
   input  logic [COORD_BITS-2:0]          req_b_w,
   input  logic [COORD_BITS-2:0]          req_b_h,
   input  logic                           req_dying,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_event_res,
   output logic                           rsp_overlap
);
   import acet_pkg::*;

   logic    push_valid;
   logic    push_stall;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_take;
   cmd_type pop_cmd;

   // Front end: takes transfers, runs the box test and classifies the command.
   acet_front #(
      .MAX_COLLIDERS (MAX_COLLIDERS),
      .COORD_BITS    (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_id_a   (req_id_a),
      .req_id_b   (req_id_b),
      .req_a_x    (req_a_x),
      .req_a_y    (req_a_y),
      .req_a_w    (req_a_w),
      .req_a_h    (req_a_h),
      .req_b_x    (req_b_x),
      .req_b_y    (req_b_y),
      .req_b_w    (req_b_w),
      .req_b_h    (req_b_h),
      .req_dying  (req_dying),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_cmd   (push_cmd)
   );

   // Command queue that decouples the two halves.
   acet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_cmd    (pop_cmd)
   );

   // Back end: pair store, forget sweeps and the result register.
   acet_back #(
      .MAX_COLLIDERS (MAX_COLLIDERS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_take      (pop_take),
      .pop_cmd       (pop_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_overlap   (rsp_overlap)
   );

endmodule

[rtl/acet_checker.sv]
module acet_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_res,
   input logic       rsp_overlap
);
   import acet_pkg::*;

   // No result can be pending right after reset, since the store is being cleared.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An enter or a stay is only reported when the boxes overlap.
   a_contact_needs_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_ENTER || rsp_event_res == EV_STAY)
         |-> rsp_overlap)
      else $error("enter or stay reported without overlap");

   // A stalled result stays offered.
   a_stall_holds_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_stall_holds_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_event_res) && $stable(rsp_overlap))
      else $error("result payload changed while stalled");

endmodule

bind aabb_contact_event_tracker_unit acet_checker u_acet_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_event_res (rsp_event_res),
   .rsp_overlap   (rsp_overlap)
);

[test/aabb_contact_event_tracker_unit_test.sv]
module aabb_contact_event_tracker_unit_test;
   import acet_pkg::*;

   localparam int COORD_W   = COORD_BITS_DEF;
   localparam int MAX_IDS   = MAX_COLLIDERS_DEF;
   localparam int CYCLE_CAP = 500000;

   // One pair test or forget command as it crosses the input channel.
   typedef struct {
      logic                      opcode;
      logic [ID_BITS-1:0]        id_a;
      logic [ID_BITS-1:0]        id_b;
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic [COORD_W-2:0]        a_w;
      logic [COORD_W-2:0]        a_h;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic [COORD_W-2:0]        b_w;
      logic [COORD_W-2:0]        b_h;
      logic                      dying;
   } pair_cmd_type;

   // One contact report as it crosses the result channel.
   typedef struct {
      event_type ev;
      logic      overlap;
   } contact_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_opcode = OP_TEST;
   logic [ID_BITS-1:0]        req_id_a = '0;
   logic [ID_BITS-1:0]        req_id_b = '0;
   logic signed [COORD_W-1:0] req_a_x = '0;
   logic signed [COORD_W-1:0] req_a_y = '0;
   logic [COORD_W-2:0]        req_a_w = '0;
   logic [COORD_W-2:0]        req_a_h = '0;
   logic signed [COORD_W-1:0] req_b_x = '0;
   logic signed [COORD_W-1:0] req_b_y = '0;
   logic [COORD_W-2:0]        req_b_w = '0;
   logic [COORD_W-2:0]        req_b_h = '0;
   logic                      req_dying = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_event_res;
   logic                      rsp_overlap;

   // Touching bits of the predictor, kept at [lower id][higher id].
   bit touching [MAX_IDS][MAX_IDS];
   contact_report_type contact_expected [$];

   int  failures = 0;
   int  cycle_count = 0;
   int  rsp_hold_cycles = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   logic [ID_BITS-1:0] id_pool [10];

   aabb_contact_event_tracker_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_id_a      (req_id_a),
      .req_id_b      (req_id_b),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_w       (req_a_w),
      .req_a_h       (req_a_h),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_w       (req_b_w),
      .req_b_h       (req_b_h),
      .req_dying     (req_dying),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_overlap   (rsp_overlap)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Exact integer overlap on one axis: twice the centre distance below the size sum.
   function automatic bit axis_overlaps(longint pa, longint sa, longint pb, longint sb);
      longint d;
      d = pa - pb;
      if (d < 0) d = -d;
      return (2 * d) < (sa + sb);
   endfunction

   // Predicts the contact report of one command and updates the touching bits.
   function automatic contact_report_type track_contact(pair_cmd_type c);
      contact_report_type r;
      bit hit;
      bit was;
      logic [ID_BITS-1:0] lo;
      logic [ID_BITS-1:0] hi;
      r.ev = EV_NONE;
      r.overlap = 1'b0;
      if (c.opcode == OP_FORGET) begin
         if (int'(c.id_a) < MAX_IDS) begin
            for (int k = 0; k < MAX_IDS; k++) begin
               touching[c.id_a][ID_BITS'(k)] = 1'b0;
               touching[ID_BITS'(k)][c.id_a] = 1'b0;
            end
         end
         return r;
      end
      hit = axis_overlaps(longint'(c.a_x), longint'(c.a_w), longint'(c.b_x), longint'(c.b_w))
         && axis_overlaps(longint'(c.a_y), longint'(c.a_h), longint'(c.b_y), longint'(c.b_h));
      r.overlap = hit;
      if (c.id_a != c.id_b && int'(c.id_a) < MAX_IDS && int'(c.id_b) < MAX_IDS) begin
         lo = (c.id_a < c.id_b) ? c.id_a : c.id_b;
         hi = (c.id_a < c.id_b) ? c.id_b : c.id_a;
         was = touching[lo][hi];
         // A dying pair can only leave contact.
         if (hit && !c.dying) begin
            r.ev = was ? EV_STAY : EV_ENTER;
            touching[lo][hi] = 1'b1;
         end else begin
            r.ev = was ? EV_EXIT : EV_NONE;
            touching[lo][hi] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic pair_cmd_type make_cmd(logic op, int ia, int ib, int ax, int ay, int aw,
                                             int ah, int bx, int by, int bw, int bh, int dy);
      pair_cmd_type c;
      c.opcode = op;
      c.id_a = ID_BITS'(ia);
      c.id_b = ID_BITS'(ib);
      c.a_x = COORD_W'(ax);
      c.a_y = COORD_W'(ay);
      c.a_w = (COORD_W-1)'(aw);
      c.a_h = (COORD_W-1)'(ah);
      c.b_x = COORD_W'(bx);
      c.b_y = COORD_W'(by);
      c.b_w = (COORD_W-1)'(bw);
      c.b_h = (COORD_W-1)'(bh);
      c.dying = 1'(dy);
      return c;
   endfunction

   // Places two boxes on one axis so that they overlap or not, as asked.
   function automatic void place_axis(bit hit, output logic signed [COORD_W-1:0] pa,
                                      output logic signed [COORD_W-1:0] pb,
                                      output logic [COORD_W-2:0] sa,
                                      output logic [COORD_W-2:0] sb);
      int base;
      int wa;
      int wb;
      int sum;
      int d;
      base = int'($urandom_range(60000)) - 30000;
      wa = $urandom_range(2000);
      wb = $urandom_range(2000);
      sum = wa + wb;
      if (hit) d = (sum == 0) ? 0 : $urandom_range((sum - 1) / 2);
      else d = $urandom_range(sum + 500, (sum + 1) / 2);
      if ($urandom_range(1)) d = -d;
      pa = COORD_W'(base);
      pb = COORD_W'(base + d);
      sa = (COORD_W-1)'(wa);
      sb = (COORD_W-1)'(wb);
   endfunction

   // Draws one id from the small pool of tracked colliders.
   function automatic logic [ID_BITS-1:0] pick_pool_id();
      return id_pool[4'($urandom_range(9))];
   endfunction

   // Random command: mostly pair tests over a small id pool, some forgets and noise.
   function automatic pair_cmd_type make_tracking_cmd();
      pair_cmd_type c;
      int pick;
      bit want_hit;
      bit miss_x;
      pick = $urandom_range(99);
      c.opcode = 1'($urandom);
      c.id_a = ID_BITS'($urandom);
      c.id_b = ID_BITS'($urandom);
      c.a_x = COORD_W'($urandom);
      c.a_y = COORD_W'($urandom);
      c.a_w = (COORD_W-1)'($urandom);
      c.a_h = (COORD_W-1)'($urandom);
      c.b_x = COORD_W'($urandom);
      c.b_y = COORD_W'($urandom);
      c.b_w = (COORD_W-1)'($urandom);
      c.b_h = (COORD_W-1)'($urandom);
      c.dying = 1'($urandom);
      if (pick < 8) return c;
      if (pick < 14) begin
         c.opcode = OP_FORGET;
         c.id_a = pick_pool_id();
         return c;
      end
      c.opcode = OP_TEST;
      c.id_a = pick_pool_id();
      c.id_b = pick_pool_id();
      if (c.id_a == c.id_b) c.id_b = pick_pool_id();
      want_hit = ($urandom_range(99) < 60);
      miss_x = 1'($urandom_range(1));
      place_axis(want_hit || !miss_x ? (want_hit ? 1'b1 : bit'($urandom_range(1))) : 1'b0,
                 c.a_x, c.b_x, c.a_w, c.b_w);
      place_axis(want_hit || miss_x ? (want_hit ? 1'b1 : bit'($urandom_range(1))) : 1'b0,
                 c.a_y, c.b_y, c.a_h, c.b_h);
      c.dying = ($urandom_range(99) < 10);
      return c;
   endfunction

   // Offers one command and returns at the edge of its transfer, valid still high.
   task automatic send_cmd(pair_cmd_type c);
      int gap;
      gap = req_calm ? 0 : $urandom_range(15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= c.opcode;
      req_id_a   <= c.id_a;
      req_id_b   <= c.id_b;
      req_a_x    <= c.a_x;
      req_a_y    <= c.a_y;
      req_a_w    <= c.a_w;
      req_a_h    <= c.a_h;
      req_b_x    <= c.b_x;
      req_b_y    <= c.b_y;
      req_b_w    <= c.b_w;
      req_b_h    <= c.b_h;
      req_dying  <= c.dying;
      do @(posedge clock); while (req_stall !== 1'b0);
      contact_expected.insert(contact_expected.size(), track_contact(c));
   endtask

   // Lowers valid and waits until every predicted report has arrived.
   task automatic wait_reports_done();
      req_valid <= 1'b0;
      while (contact_expected.size() != 0) @(posedge clock);
   endtask

   // Result side: checks each transfer and draws its own stalls.
   initial begin
      int stall_left;
      int seen;
      contact_report_type exp_r;
      stall_left = 0;
      seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (contact_expected.size() == 0) begin
               $error("unexpected result: event_res %0d overlap %0d", rsp_event_res,
                      rsp_overlap);
               failures++;
            end else begin
               exp_r = contact_expected.pop_front();
               if (rsp_event_res !== exp_r.ev) begin
                  $error("event_res: expected %0d, actual %0d", exp_r.ev, rsp_event_res);
                  failures++;
               end
               if (rsp_overlap !== exp_r.overlap) begin
                  $error("overlap: expected %0d, actual %0d", exp_r.overlap, rsp_overlap);
                  failures++;
               end
            end
            seen++;
            if (seen % 64 == 0) rsp_calm = ($urandom_range(2) == 0);
            stall_left = rsp_calm ? 0 : $urandom_range(15);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Field extremes, the overlap boundary, every event, equal ids and forgets.
   task automatic test_directed_cases();
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 0));          // enter
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 3, 3, 10, 10, 0));          // stay
      send_cmd(make_cmd(OP_TEST, 2, 1, 0, 0, 10, 10, -3, 0, 10, 10, 0));         // swapped ids
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 10, 0, 10, 10, 0));         // touching edge
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 9, 0, 10, 10, 0));          // just inside
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 1));          // dying exit
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 1));          // dying, clear
      send_cmd(make_cmd(OP_TEST, 1, 2, 0, 0, 10, 10, 50, 50, 10, 10, 0));        // apart, clear
      send_cmd(make_cmd(OP_TEST, 5, 5, 0, 0, 10, 10, 0, 0, 10, 10, 0));          // equal ids
      send_cmd(make_cmd(OP_TEST, 0, 0, 0, 0, 10, 10, 90, 0, 10, 10, 1));
      send_cmd(make_cmd(OP_TEST, 0, 63, -32768, -32768, 32767, 32767,
                        32767, 32767, 32767, 32767, 0));
      send_cmd(make_cmd(OP_TEST, 0, 63, 32767, -32768, 32767, 32767,
                        32767, -32768, 32767, 32767, 0));
      send_cmd(make_cmd(OP_TEST, 63, 0, 32767, -32768, 0, 0, 32767, -32768, 0, 0, 0));
      send_cmd(make_cmd(OP_TEST, 3, 4, 0, 0, 8, 4, 0, 5, 8, 6, 0));              // y edge
      send_cmd(make_cmd(OP_TEST, 3, 4, 0, 0, 8, 4, 0, 4, 8, 6, 0));
      send_cmd(make_cmd(OP_TEST, 3, 5, 0, 0, 8, 4, 0, 0, 8, 6, 0));
      send_cmd(make_cmd(OP_FORGET, 3, 4, 0, 0, 8, 4, 0, 0, 8, 6, 0));
      send_cmd(make_cmd(OP_TEST, 5, 3, 0, 0, 8, 4, 0, 0, 8, 6, 0));              // enters again
      send_cmd(make_cmd(OP_TEST, 4, 3, 0, 0, 8, 4, 0, 0, 8, 6, 0));
      send_cmd(make_cmd(OP_TEST, 63, 0, -5, 7, 100, 100, 5, 7, 100, 100, 0));
      send_cmd(make_cmd(OP_FORGET, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_cmd(make_cmd(OP_TEST, 0, 63, -5, 7, 100, 100, 5, 7, 100, 100, 0));
      send_cmd(make_cmd(OP_TEST, 0, 63, 0, 0, 100, 10, 0, 500, 100, 10, 0));     // x only
      send_cmd(make_cmd(OP_FORGET, 0, 0, -1, -1, 32767, 32767, -1, -1, 32767, 32767, 1));
   endtask

   // Long tracking sequences over a small id pool, with runs of calm and busy handshakes.
   task automatic test_random_tracking(int count);
      for (int k = 0; k < 10; k++) id_pool[4'(k)] = ID_BITS'($urandom);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) req_calm = ($urandom_range(2) == 0);
         send_cmd(make_tracking_cmd());
      end
   endtask

   // The receiver holds off while commands keep coming, so the block fills and stalls.
   task automatic test_full_backpressure();
      req_calm = 1'b1;
      rsp_hold_cycles = 400;
      for (int i = 0; i < 30; i++) send_cmd(make_tracking_cmd());
      req_calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_reports_done();
      test_random_tracking(400);
      wait_reports_done();
      test_full_backpressure();
      wait_reports_done();
      test_random_tracking(350);
      wait_reports_done();
      repeat (20) @(posedge clock);
      if (failures == 0 && contact_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
